FILE: hdl/tzeq_pkg.sv
// ----------------------------------------------------------------------------
// tzeq_pkg
// Shared constants and codes for the touch zone event qualifier: zone layout,
// electrode field format, tick counter width and configuration indexes.
// ----------------------------------------------------------------------------
package tzeq_pkg;

	// zone layout
	localparam int NUM_ZONES  = 6;
	localparam int LEFT_ZONE  = 3;
	localparam int RIGHT_ZONE = 4;
	localparam int BOTH_ZONE  = 5;

	// electrode bitmap and per-zone electrode field
	localparam int ELEC_W         = 12;
	localparam int FIELD_W        = 5;
	localparam int SEL_W          = 4;
	localparam int ELECTRODE_LAST = 11;
	localparam int MAP_W          = NUM_ZONES * FIELD_W;

	// tick counters
	localparam int TICK_W = 16;
	localparam logic [TICK_W-1:0] TICK_MAX = '1;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = MAP_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ZONE_ENABLE = 2'd0,
		CFG_ELECTRODE   = 2'd1,
		CFG_REFRACTORY  = 2'd2,
		CFG_COALESCE    = 2'd3
	} cfg_reg_t;

	// per-lane setup handed from the top level to each lane
	typedef struct packed {
		logic                 enable;
		logic                 sampled;
		logic                 ordinary;
		logic [FIELD_W-1:0]   electrode;
	} lane_cfg_t;

endpackage

FILE: hdl/tzeq_lane.sv
// ----------------------------------------------------------------------------
// tzeq_lane
// One zone lane: picks the zone's electrode, detects a rising touch, keeps the
// ticks-since-fire counter and qualifies fires against the refractory count.
// ----------------------------------------------------------------------------
module tzeq_lane (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             step,
	input  logic [tzeq_pkg::ELEC_W-1:0]      touched,
	input  tzeq_pkg::lane_cfg_t              cfg,
	input  logic [tzeq_pkg::TICK_W-1:0]      refractory,
	input  logic                             extra_req,
	output logic                             rise,
	output logic                             fire
);
	import tzeq_pkg::*;

	logic                    prev_q;
	logic [TICK_W-1:0]       since_q;
	logic [2**SEL_W-1:0]     touched_ext;
	logic                    assigned;
	logic                    now_touched;
	logic                    prev_next;
	logic [TICK_W-1:0]       since_inc;
	logic [TICK_W-1:0]       since_mid;
	logic                    ord_fire;
	logic                    extra_ok;

	// electrode select and edge detect
	assign touched_ext = {{(2**SEL_W-ELEC_W){1'b0}}, touched};
	assign assigned    = cfg.enable && cfg.sampled &&
		(cfg.electrode <= FIELD_W'(ELECTRODE_LAST));
	assign now_touched = touched_ext[cfg.electrode[SEL_W-1:0]];
	assign prev_next   = assigned && now_touched;
	assign rise        = prev_next && !prev_q;

	// saturating tick count, then ordinary fire before any late attempt
	assign since_inc = (since_q == TICK_MAX) ? since_q : since_q + TICK_W'(1);
	assign ord_fire  = rise && cfg.ordinary && (since_inc >= refractory);
	assign since_mid = ord_fire ? '0 : since_inc;
	assign extra_ok  = since_mid >= refractory;
	assign fire      = ord_fire || (extra_req && extra_ok);

	// lane state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= 1'b0;
			since_q <= '0;
		end else if (step) begin
			prev_q  <= prev_next;
			since_q <= fire ? '0 : since_inc;
		end
	end

endmodule

FILE: hdl/tzeq_merge.sv
// ----------------------------------------------------------------------------
// tzeq_merge
// Cheek coalescing: holds the left and right pendings with their countdowns,
// pairs opposite cheek rises into the both zone and expires old pendings.
// ----------------------------------------------------------------------------
module tzeq_merge (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               step,
	input  logic [tzeq_pkg::NUM_ZONES-1:0]     rise,
	input  logic [tzeq_pkg::TICK_W-1:0]        coalesce,
	input  logic                               both_enable,
	output logic [tzeq_pkg::NUM_ZONES-1:0]     extra_req
);
	import tzeq_pkg::*;

	logic [1:0]              pend_q;
	logic [TICK_W-1:0]       ticks_q [2];
	logic [1:0]              pend_d;
	logic [TICK_W-1:0]       ticks_d [2];
	logic [1:0]              expire;
	logic                    both_req;
	logic                    coal_on;

	assign coal_on = coalesce != '0;

	// countdown, pairing in zone order, then expiry
	always_comb begin
		pend_d   = pend_q;
		both_req = 1'b0;
		expire   = 2'b00;
		for (int i = 0; i < 2; i++) begin
			ticks_d[i] = (pend_q[i] && ticks_q[i] != '0) ?
				ticks_q[i] - TICK_W'(1) : ticks_q[i];
		end
		// left cheek comes first
		if (coal_on && rise[LEFT_ZONE]) begin
			if (pend_d[1]) begin
				pend_d   = 2'b00;
				both_req = 1'b1;
			end else begin
				pend_d[0]  = 1'b1;
				ticks_d[0] = coalesce;
			end
		end
		if (coal_on && rise[RIGHT_ZONE]) begin
			if (pend_d[0]) begin
				pend_d   = 2'b00;
				both_req = 1'b1;
			end else begin
				pend_d[1]  = 1'b1;
				ticks_d[1] = coalesce;
			end
		end
		for (int i = 0; i < 2; i++) begin
			if (pend_d[i] && ticks_d[i] == '0) begin
				expire[i] = 1'b1;
				pend_d[i] = 1'b0;
			end
		end
		extra_req             = '0;
		extra_req[LEFT_ZONE]  = expire[0];
		extra_req[RIGHT_ZONE] = expire[1];
		extra_req[BOTH_ZONE]  = both_req && both_enable;
	end

	// pending state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q     <= 2'b00;
			ticks_q[0] <= '0;
			ticks_q[1] <= '0;
		end else if (step) begin
			pend_q     <= pend_d;
			ticks_q[0] <= ticks_d[0];
			ticks_q[1] <= ticks_d[1];
		end
	end

endmodule

FILE: hdl/tzeq_outbuf.sv
// ----------------------------------------------------------------------------
// tzeq_outbuf
// Output register with a skid entry, so a new beat is taken while a finished
// result still waits downstream.
// ----------------------------------------------------------------------------
module tzeq_outbuf (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [tzeq_pkg::NUM_ZONES-1:0]     in_data,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [tzeq_pkg::NUM_ZONES-1:0]     out_data
);
	import tzeq_pkg::*;

	logic                    out_valid_q;
	logic                    skid_valid_q;
	logic [NUM_ZONES-1:0]    out_data_q;
	logic [NUM_ZONES-1:0]    skid_data_q;
	logic                    take;
	logic                    acc;

	assign in_stall  = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign take      = out_valid_q && !out_stall;
	assign acc       = in_valid && !skid_valid_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || take) begin
			out_valid_q  <= skid_valid_q || acc;
			skid_valid_q <= 1'b0;
		end else if (acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (!out_valid_q || take) begin
			out_data_q <= skid_valid_q ? skid_data_q : in_data;
		end else if (acc) begin
			skid_data_q <= in_data;
		end
	end

endmodule

FILE: hdl/touch_zone_event_qualifier.sv
// ----------------------------------------------------------------------------
// touch_zone_event_qualifier
// Qualifies per-zone touch events from a polled electrode bitmap, with
// per-zone refractory counts and left/right cheek coalescing.
// ----------------------------------------------------------------------------
// lanes and cheek pairing are combinational; the fire mask is registered
// throughput: one beat per cycle while the skid entry is empty
// a two-entry output buffer keeps input open while one result waits
// reset clears zone state, pendings and configuration to their defaults
// ----------------------------------------------------------------------------
module touch_zone_event_qualifier (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [tzeq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tzeq_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [tzeq_pkg::ELEC_W-1:0]        touched,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [tzeq_pkg::NUM_ZONES-1:0]     fire_mask
);
	import tzeq_pkg::*;

	logic [NUM_ZONES-1:0]    enable_q;
	logic [MAP_W-1:0]        map_q;
	logic [TICK_W-1:0]       refractory_q;
	logic [TICK_W-1:0]       coalesce_q;
	logic                    step;
	logic [NUM_ZONES-1:0]    rise;
	logic [NUM_ZONES-1:0]    fire;
	logic [NUM_ZONES-1:0]    extra_req;
	lane_cfg_t               lane_cfg [NUM_ZONES];

	assign step = in_valid && !in_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q     <= '0;
			map_q        <= '1;
			refractory_q <= '0;
			coalesce_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_ZONE_ENABLE: enable_q     <= cfg_data[NUM_ZONES-1:0];
				CFG_ELECTRODE:   map_q        <= cfg_data[MAP_W-1:0];
				CFG_REFRACTORY:  refractory_q <= cfg_data[TICK_W-1:0];
				CFG_COALESCE:    coalesce_q   <= cfg_data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// one lane per zone
	for (genvar z = 0; z < NUM_ZONES; z++) begin : g_lane
		assign lane_cfg[z].enable    = enable_q[z];
		assign lane_cfg[z].sampled   = (z != BOTH_ZONE);
		assign lane_cfg[z].ordinary  = ((z != LEFT_ZONE) && (z != RIGHT_ZONE)) ||
			(coalesce_q == '0);
		assign lane_cfg[z].electrode = map_q[z*FIELD_W +: FIELD_W];

		tzeq_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.step       (step),
			.touched    (touched),
			.cfg        (lane_cfg[z]),
			.refractory (refractory_q),
			.extra_req  (extra_req[z]),
			.rise       (rise[z]),
			.fire       (fire[z])
		);
	end

	// cheek pairing across lanes
	tzeq_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.rise        (rise),
		.coalesce    (coalesce_q),
		.both_enable (enable_q[BOTH_ZONE]),
		.extra_req   (extra_req)
	);

	// result buffering
	tzeq_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (fire),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (fire_mask)
	);

endmodule

FILE: hdl/tzeq_checker.sv
// ----------------------------------------------------------------------------
// tzeq_checker
// Port-level checks on the qualifier's handshakes and buffering, bound to the
// top level.
// ----------------------------------------------------------------------------
module tzeq_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	input  logic                               in_stall,
	input  logic                               out_valid,
	input  logic                               out_stall,
	input  logic [tzeq_pkg::NUM_ZONES-1:0]     fire_mask
);

	// a stalled result beat stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result beat dropped while stalled");

	// a stalled result beat keeps its mask
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(fire_mask))
		else $error("result mask changed while stalled");

	// input is pushed back only while a result is waiting
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result pending");

	// pushback starts only after a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(out_valid && out_stall))
		else $error("input stall rose without output pushback");

	// an accepted beat into an empty block shows up next cycle
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && in_valid && !in_stall |=> out_valid)
		else $error("result missing one cycle after accept");

endmodule

bind touch_zone_event_qualifier tzeq_checker u_tzeq_checker (.*);
